>>> rtl/lphl_pkg.sv
// lphl_pkg: shared widths, stream packing and item codes for the hash lookup block
`timescale 1ns / 1ps
`default_nettype none

package lphl_pkg;

    // field widths fixed by the item format
    localparam int SLOT_IDX_W = 10;
    localparam int KEY_W      = 32;
    localparam int CAP_W      = 11;

    // stream payload widths, padded to whole bytes
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 16;

    // input tdata field positions, lowest bit first
    localparam int IN_IDX_LSB  = 0;
    localparam int IN_SKEY_LSB = IN_IDX_LSB + SLOT_IDX_W;
    localparam int IN_OCC_BIT  = IN_SKEY_LSB + KEY_W;
    localparam int IN_LKEY_LSB = IN_OCC_BIT + 1;

    // item kind carried in tuser
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

endpackage

`default_nettype wire

>>> rtl/linear_probe_hash_lookup.sv
// linear_probe_hash_lookup: open-addressing hash table lookup with linear probing
// write item: slot updated at the accepting edge, no result
// lookup item: a 4-bit-per-cycle remainder unit finds the home slot, then slots are probed
//   at 1 per cycle, one memory read per probe
// zero capacity: no division or probe, a miss goes straight to the result hold state; one item in flight at a time
// reset: synchronous active low; a clearing pass then empties every slot, no item is taken
//   during it, capacity writes are taken at any time
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_lookup #(
    parameter int TABLE_DEPTH = 1024
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // capacity write channel
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [lphl_pkg::CAP_W-1:0]       i_cfg_data,
    // input items
    input  wire                              i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata: slot_index[9:0], slot_key[41:10], slot_occupied[42], lookup_key[74:43], zero pad
    input  wire  [lphl_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: mode[0]
    input  wire  [0:0]                       i_s_axis_tuser,
    // result items
    output logic                             o_m_axis_tvalid,
    input  wire                              i_m_axis_tready,
    // tdata: found_slot[9:0], zero pad
    output logic [lphl_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // tuser: found[0]
    output logic [0:0]                       o_m_axis_tuser
);
    import lphl_pkg::*;

    localparam int IW       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int DW       = $clog2(TABLE_DEPTH + 1);
    localparam int CAPW     = (DW > CAP_W) ? DW : CAP_W;
    localparam int DIV_BITS = 4;
    localparam int DIV_CYC  = KEY_W / DIV_BITS;
    localparam int DCW      = $clog2(DIV_CYC);
    localparam int ENTRY_W  = KEY_W + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_FIX,
        S_PROBE,
        S_HOLD
    } t_state;

    t_state              r_state;
    logic [IW-1:0]       r_clr_cnt;
    logic [CAP_W-1:0]    r_capacity;
    logic [CAPW-1:0]     r_cap;
    logic [KEY_W-1:0]    r_key;
    logic                r_neg;
    logic [KEY_W-1:0]    r_quo;
    logic [CAPW-1:0]     r_rem;
    logic [DCW-1:0]      r_div_cnt;
    logic [IW-1:0]       r_idx;
    logic [IW-1:0]       r_start;
    logic                r_hit;
    logic [IW-1:0]       r_where;
    logic                r_out_valid;
    logic                r_out_found;
    logic [SLOT_IDX_W-1:0] r_out_slot;

    logic [ENTRY_W-1:0]  mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0]  r_rd_data;

    logic                in_accept;
    logic                wr_in_range;
    logic                mem_we;
    logic [IW-1:0]       mem_wa;
    logic [ENTRY_W-1:0]  mem_wd;
    logic [IW-1:0]       rd_addr;
    logic [CAPW-1:0]     eff_cap;
    logic [KEY_W-1:0]    in_lkey;
    logic [KEY_W-1:0]    key_mag;
    logic [CAPW:0]       div_t;
    logic [CAPW-1:0]     n_rem;
    logic [KEY_W-1:0]    n_quo;
    logic [CAPW-1:0]     home_full;
    logic [IW-1:0]       home;
    logic [CAPW-1:0]     idx_inc;
    logic [IW-1:0]       nxt;

    // handshakes
    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    // input decode
    assign in_lkey     = i_s_axis_tdata[IN_LKEY_LSB +: KEY_W];
    assign key_mag     = in_lkey[KEY_W-1] ? (~in_lkey + 1'b1) : in_lkey;
    assign wr_in_range = 32'(i_s_axis_tdata[IN_IDX_LSB +: SLOT_IDX_W]) < 32'(TABLE_DEPTH);
    assign eff_cap     = (CAPW'(r_capacity) > CAPW'(TABLE_DEPTH)) ?
                         CAPW'(TABLE_DEPTH) : CAPW'(r_capacity);

    // remainder unit: DIV_BITS restoring steps per cycle
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        div_t = '0;
        for (int k = 0; k < DIV_BITS; k++) begin
            div_t = {n_rem, n_quo[KEY_W-1]};
            n_quo = {n_quo[KEY_W-2:0], 1'b0};
            if (div_t >= {1'b0, r_cap}) begin
                div_t = div_t - {1'b0, r_cap};
            end
            n_rem = div_t[CAPW-1:0];
        end
    end

    // home slot: truncating remainder moved into range for negative keys
    assign home_full = (r_neg && (r_rem != '0)) ? (r_cap - r_rem) : r_rem;
    assign home      = home_full[IW-1:0];

    // next probe slot with wrap at capacity
    assign idx_inc = CAPW'(r_idx) + 1'b1;
    assign nxt     = (idx_inc >= r_cap) ? '0 : idx_inc[IW-1:0];

    // memory port selection
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_clr_cnt;
        mem_wd = '0;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
        end else if (in_accept && (i_s_axis_tuser[0] == MODE_WRITE) && wr_in_range) begin
            mem_we = 1'b1;
            mem_wa = IW'(i_s_axis_tdata[IN_IDX_LSB +: SLOT_IDX_W]);
            mem_wd = {i_s_axis_tdata[IN_OCC_BIT], i_s_axis_tdata[IN_SKEY_LSB +: KEY_W]};
        end
    end

    always_comb begin
        case (r_state)
            S_FIX:   rd_addr = home;
            S_PROBE: rd_addr = nxt;
            default: rd_addr = r_idx;
        endcase
    end

    // slot memory: occupied flag above the key, one write and one read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[rd_addr];
    end

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_capacity <= i_cfg_data;
        end
    end

    // control sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (32'(r_clr_cnt) == 32'(TABLE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept && (i_s_axis_tuser[0] == MODE_LOOKUP)) begin
                        r_cap     <= eff_cap;
                        r_key     <= in_lkey;
                        r_neg     <= in_lkey[KEY_W-1];
                        r_quo     <= key_mag;
                        r_rem     <= '0;
                        r_div_cnt <= '0;
                        r_hit     <= 1'b0;
                        r_where   <= '0;
                        r_state   <= (eff_cap == '0) ? S_HOLD : S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem     <= n_rem;
                    r_quo     <= n_quo;
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (32'(r_div_cnt) == 32'(DIV_CYC - 1)) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    r_idx   <= home;
                    r_start <= home;
                    r_state <= S_PROBE;
                end
                S_PROBE: begin
                    if (!r_rd_data[KEY_W]) begin
                        r_state <= S_HOLD;
                    end else if (r_rd_data[KEY_W-1:0] == r_key) begin
                        r_hit   <= 1'b1;
                        r_where <= r_idx;
                        r_state <= S_HOLD;
                    end else if (nxt == r_start) begin
                        r_state <= S_HOLD;
                    end else begin
                        r_idx <= nxt;
                    end
                end
                S_HOLD: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= r_hit;
                        r_out_slot  <= SLOT_IDX_W'(r_where);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result outputs
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_out_slot);
    assign o_m_axis_tuser  = r_out_found;

endmodule

`default_nettype wire

>>> rtl/lphl_checker.sv
// lphl_checker: port-level assertions for the hash lookup block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module lphl_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_s_axis_tvalid,
    input wire                              o_s_axis_tready,
    input wire [0:0]                        i_s_axis_tuser,
    input wire                              o_m_axis_tvalid,
    input wire                              i_m_axis_tready,
    input wire [lphl_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input wire [0:0]                        o_m_axis_tuser
);
    import lphl_pkg::*;

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // a miss reports slot zero and padding stays zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata[OUT_TDATA_W-1:SLOT_IDX_W] == '0) &&
            (o_m_axis_tuser[0] || (o_m_axis_tdata == '0)))
        else $error("bad result payload");

    // a lookup transaction blocks the input in the next cycle
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser[0] == MODE_LOOKUP) |=>
            !o_s_axis_tready)
        else $error("input taken during lookup");

    // clearing pass keeps the input closed right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_s_axis_tready)
        else $error("input open before clearing pass");

endmodule

bind linear_probe_hash_lookup lphl_checker u_lphl_checker (.*);

`default_nettype wire

>>> tb/sv/lphl_lookup_checker.sv
// lphl_lookup_checker: watches the hash lookup channels, predicts each lookup answer and compares
`timescale 1ns / 1ps

module lphl_lookup_checker (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_valid,
    input  wire                                i_cfg_ready,
    input  wire  [lphl_pkg::CAP_W-1:0]         i_cfg_data,
    input  wire                                i_s_tvalid,
    input  wire                                i_s_tready,
    // tdata: slot_index, slot_key, slot_occupied, lookup_key, zero pad
    input  wire  [lphl_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // tuser: mode
    input  wire  [0:0]                         i_s_tuser,
    input  wire                                i_m_tvalid,
    input  wire                                i_m_tready,
    // tdata: found_slot, zero pad
    input  wire  [lphl_pkg::OUT_TDATA_W-1:0]   i_m_tdata,
    // tuser: found
    input  wire  [0:0]                         i_m_tuser,
    output int                                 o_fail_count,
    output int                                 o_pending
);

    import lphl_pkg::*;

    localparam int SLOTS = 1024;

    typedef struct packed {
        logic                  found;
        logic [SLOT_IDX_W-1:0] slot;
    } t_lookup_answer;

    // shadow copy of the table and the capacity register
    logic [KEY_W-1:0]   shadow_keys [SLOTS];
    logic               shadow_occ  [SLOTS];
    logic [CAP_W-1:0]   shadow_cap;
    t_lookup_answer     lookup_answers_q[$];
    int                 fails = 0;

    // linear probe walk over the shadow table
    function automatic t_lookup_answer probe_table(input logic [KEY_W-1:0] want);
        t_lookup_answer res;
        int unsigned    cap;
        longint signed  k;
        longint signed  rem;
        int unsigned    start;
        int unsigned    pos;
        res = '0;
        cap = (shadow_cap > SLOTS) ? SLOTS : shadow_cap;
        if (cap == 0) return res;
        k   = $signed(want);
        rem = k % longint'(cap);
        if (rem < 0) rem += cap;
        start = 32'(rem);
        pos   = start;
        do begin
            if (!shadow_occ[pos]) break;
            if (shadow_keys[pos] == want) begin
                res.found = 1'b1;
                res.slot  = SLOT_IDX_W'(pos);
                break;
            end
            pos = (pos + 1 == cap) ? 0 : pos + 1;
        end while (pos != start);
        return res;
    endfunction

    // report one mismatch
    task automatic note_mismatch(input string what, input longint exp_v, input longint got_v);
        fails++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, got_v);
    endtask

    // per-edge bookkeeping: config, result compare, input prediction
    always @(posedge i_clk) begin
        t_lookup_answer got;
        t_lookup_answer exp_a;
        if (!i_rst_n) begin
            shadow_cap = '0;
            foreach (shadow_occ[n]) shadow_occ[n] = 1'b0;
            lookup_answers_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                shadow_cap = i_cfg_data;
            if (i_m_tvalid && i_m_tready) begin
                got.found = i_m_tuser[0];
                got.slot  = i_m_tdata[SLOT_IDX_W-1:0];
                if (lookup_answers_q.size() == 0) begin
                    fails++;
                    $display("%0t: result with none expected, found %0d slot %0d",
                             $time, got.found, got.slot);
                end else begin
                    exp_a = lookup_answers_q.pop_front();
                    if (got.found !== exp_a.found)
                        note_mismatch("found", exp_a.found, got.found);
                    if (got.slot !== exp_a.slot)
                        note_mismatch("found_slot", exp_a.slot, got.slot);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0] == MODE_WRITE) begin
                    shadow_keys[i_s_tdata[IN_IDX_LSB +: SLOT_IDX_W]] =
                        i_s_tdata[IN_SKEY_LSB +: KEY_W];
                    shadow_occ[i_s_tdata[IN_IDX_LSB +: SLOT_IDX_W]] = i_s_tdata[IN_OCC_BIT];
                end else begin
                    lookup_answers_q.push_back(probe_table(i_s_tdata[IN_LKEY_LSB +: KEY_W]));
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= lookup_answers_q.size();
    end

endmodule

>>> tb/sv/tb_top.sv
// tb_top: drives table writes, lookups and capacity settings into the hash lookup block
`timescale 1ns / 1ps

module tb_top;

    import lphl_pkg::*;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CAP_W-1:0]        cfg_data;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata;
    logic [0:0]              s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic [0:0]              m_tuser;
    int                      fail_count;
    int                      pending;
    int                      quiet_left = 0;

    always #5 i_clk = ~i_clk;

    linear_probe_hash_lookup i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    lphl_lookup_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // sender gap: mostly none or short, a few long, with gap-free bursts
    function automatic int pick_gap();
        int pick;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            quiet_left = $urandom_range(20, 40);
            return 0;
        end
        if (pick < 55) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // offer one item and hold it until the transaction completes
    task automatic send_item(input logic mode, input logic [SLOT_IDX_W-1:0] idx,
                             input logic [KEY_W-1:0] skey, input logic occ,
                             input logic [KEY_W-1:0] lkey);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, lkey, occ, skey, idx};
        s_tuser  <= mode;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic write_slot(input int idx, input logic [KEY_W-1:0] key, input logic occ);
        send_item(MODE_WRITE, SLOT_IDX_W'(idx), key, occ, $urandom);
    endtask

    task automatic look_up(input logic [KEY_W-1:0] key);
        send_item(MODE_LOOKUP, SLOT_IDX_W'($urandom), $urandom,
                  1'($urandom_range(0, 1)), key);
    endtask

    // stop offering and wait for every outstanding lookup answer
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // capacity writes only with the block idle
    task automatic set_capacity(input int cap);
        wait_drained();
        repeat (20) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= CAP_W'(cap);
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // random writes and lookups over a key pool with clustered homes
    task automatic run_phase(input int cap, input int n_items);
        int unsigned      eff;
        int unsigned      base;
        logic [KEY_W-1:0] pool [16];
        logic [KEY_W-1:0] key;
        int               idx;
        set_capacity(cap);
        eff  = (cap > 1024) ? 1024 : cap;
        base = $urandom_range(0, 5000);
        for (int i = 0; i < 16; i++) begin
            case (i % 4)
                0: pool[i] = $urandom;
                1: pool[i] = base + i * eff;
                2: pool[i] = -(base + i * eff) - 1;
                default: begin
                    case (i / 4)
                        0: pool[i] = 32'h8000_0000;
                        1: pool[i] = 32'h7fff_ffff;
                        2: pool[i] = 32'h0000_0000;
                        default: pool[i] = 32'hffff_ffff;
                    endcase
                end
            endcase
        end
        for (int n = 0; n < n_items; n++) begin
            if ($urandom_range(0, 99) == 0) wait_drained();
            key = ($urandom_range(0, 99) < 75) ? pool[$urandom_range(0, 15)] : $urandom;
            if ($urandom_range(0, 99) < 45) begin
                if (eff > 0 && $urandom_range(0, 99) < 85) idx = $urandom_range(0, eff - 1);
                else idx = $urandom_range(0, 1023);
                write_slot(idx, key, $urandom_range(0, 99) < 85);
            end else begin
                look_up(key);
            end
        end
    endtask

    // receiver ready: random stalls, a forced long hold-off, gap-free stretches
    initial begin : result_ready
        int   pick;
        int   seg;
        int   cycles;
        bit   forced_done;
        logic level;
        cycles      = 0;
        forced_done = 1'b0;
        m_tready <= 1'b0;
        repeat (12) @(posedge i_clk);
        forever begin
            pick = $urandom_range(0, 99);
            if (!forced_done && cycles > 4000) begin
                level       = 1'b0;
                seg         = 400;
                forced_done = 1'b1;
            end else if (pick < 10) begin
                level = 1'b1;
                seg   = $urandom_range(20, 80);
            end else if (pick < 13) begin
                level = 1'b0;
                seg   = $urandom_range(30, 150);
            end else if (pick < 45) begin
                level = 1'b0;
                seg   = $urandom_range(1, 3);
            end else begin
                level = 1'b1;
                seg   = $urandom_range(1, 4);
            end
            m_tready <= level;
            repeat (seg) @(posedge i_clk);
            cycles += seg;
        end
    end

    // run limit
    initial begin
        #100_000_000;
        $display("simulation failed");
        $finish;
    end

    // reset, directed items, random phases, verdict
    initial begin
        i_rst_n   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= MODE_WRITE;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero capacity misses even on a stored key
        look_up(32'h0000_0000);
        look_up(32'h8000_0000);
        write_slot(0, 32'h0000_0000, 1'b1);
        look_up(32'h0000_0000);

        // fill a seven-slot table, including extreme keys
        set_capacity(7);
        write_slot(1, 7, 1'b1);
        write_slot(2, 32'h7fff_ffff, 1'b1);
        write_slot(3, 3, 1'b1);
        write_slot(4, 4, 1'b1);
        write_slot(5, 32'h8000_0000, 1'b1);
        write_slot(6, -1, 1'b1);
        write_slot(1023, -1, 1'b1);
        // hits after a probe, on the negative home and at the extremes
        look_up(7);
        look_up(-1);
        look_up(32'h8000_0000);
        look_up(32'h7fff_ffff);
        // full table: the miss walks the whole circle
        look_up(100);
        // cleared slot ends the walk
        write_slot(3, 3, 1'b0);
        look_up(100);
        look_up(4);
        look_up(10);

        // random phases, capacity above depth saturates
        run_phase(1, 150);
        run_phase(2, 150);
        run_phase(2047, 150);
        run_phase(13, 250);
        run_phase(1024, 150);
        run_phase(0, 60);
        run_phase(64, 250);
        run_phase(1025, 150);
        run_phase(3, 200);
        run_phase(250, 250);
        run_phase($urandom_range(4, 1024), 200);

        wait_drained();
        repeat (1100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
